### sv/dhe_pkg.sv
package dhe_pkg;

  // Default number of histogram bins.
  localparam int DEPTH_BINS_DEF = 8192;

  // Fixed field widths.
  localparam int DEPTH_W = 16;
  localparam int CFG_W   = 13;
  localparam int COUNT_W = 20;
  localparam int GRAY_W  = 8;

  // Divider geometry: the quotient of 256*(N-cum)/N never exceeds 256.
  localparam int QUOT_W = GRAY_W + 1;
  localparam int NUM_W  = COUNT_W + GRAY_W;
  localparam int STEP_W = $clog2(QUOT_W + 1);

  localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

  // Pixel modes.
  localparam logic MODE_COUNT = 1'b0;
  localparam logic MODE_MAP   = 1'b1;

  typedef struct packed {
    logic               start;
    logic [NUM_W-1:0]   num;
    logic [COUNT_W-1:0] den;
  } div_req_t;

  typedef struct packed {
    logic              done;
    logic [QUOT_W-1:0] quot;
  } div_rsp_t;

endpackage

### sv/dhe_if.sv
interface dhe_pix_if;
  import dhe_pkg::*;

  logic               valid;
  logic               ready;
  logic               mode;
  logic [DEPTH_W-1:0] depth;
  logic               last;

  modport source (output valid, output mode, output depth, output last, input ready);
  modport sink   (input valid, input mode, input depth, input last, output ready);
endinterface

interface dhe_gray_if;
  import dhe_pkg::*;

  logic              valid;
  logic              ready;
  logic [GRAY_W-1:0] gray;

  modport source (output valid, output gray, input ready);
  modport sink   (input valid, input gray, output ready);
endinterface

### sv/dhe_ram.sv
module dhe_ram #(
  parameter int WIDTH = dhe_pkg::GRAY_W,
  parameter int DEPTH = dhe_pkg::DEPTH_BINS_DEF
) (
  input  logic                             clk_i,
  input  logic                             we_i,
  input  logic [$clog2(DEPTH)-1:0]         waddr_i,
  input  logic [WIDTH-1:0]                 wdata_i,
  input  logic                             re_i,
  input  logic [$clog2(DEPTH)-1:0]         raddr_i,
  output logic [WIDTH-1:0]                 rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Read returns the old contents when both ports hit the same entry.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### sv/dhe_div.sv
module dhe_div (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  dhe_pkg::div_req_t req_i,
  output dhe_pkg::div_rsp_t rsp_o
);
  import dhe_pkg::*;

  logic              busy_q, busy_d;
  logic              done_q, done_d;
  logic [STEP_W-1:0] cnt_q, cnt_d;
  logic [NUM_W-1:0]  rem_q, rem_d;
  logic [NUM_W-1:0]  dsh_q, dsh_d;
  logic [QUOT_W-1:0] quot_q, quot_d;
  logic              fits;

  // Restoring division, one quotient bit per cycle, most significant first.
  assign fits = (rem_q >= dsh_q);

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    dsh_d  = dsh_q;
    quot_d = quot_q;
    if (req_i.start) begin
      busy_d = 1'b1;
      cnt_d  = STEP_W'(QUOT_W);
      rem_d  = req_i.num;
      dsh_d  = {req_i.den, {GRAY_W{1'b0}}};
      quot_d = '0;
    end else if (busy_q) begin
      if (fits) begin
        rem_d = rem_q - dsh_q;
      end
      quot_d = {quot_q[QUOT_W-2:0], fits};
      dsh_d  = dsh_q >> 1;
      cnt_d  = cnt_q - 1'b1;
      if (cnt_q == STEP_W'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q  <= rem_d;
    dsh_q  <= dsh_d;
    quot_q <= quot_d;
  end

  assign rsp_o.done = done_q;
  assign rsp_o.quot = quot_q;

endmodule

### sv/depth_histogram_equalizer_unit.sv
// Depth histogram equalizer. A depth frame is streamed twice: first with mode
// set to count, then with mode set to map. Both passes take one pixel beat per
// clock while the result side keeps up. A pixel is valid when its depth is
// above the configured depth floor and below DEPTH_BINS. In the counting pass
// each valid pixel bumps its bin in the count memory by a read-modify-write
// through a two-stage pipeline with forwarding, so repeated depths in
// back-to-back beats count correctly. The counting beat with last set starts
// the bin walk, during which no pixel beat is taken. Each bin of the walk
// goes through a count read, the running sum, and a nine-step radix-2 divider
// that forms floor(256*(N-cum)/N), followed by the write into the gray table;
// the walk also clears each count. The mapping pass reads the gray table, one
// result beat per pixel beat, through the gray table read register and the
// output register. After reset the count memory is swept to zero bin by bin
// before the first pixel beat is taken; configuration writes are accepted at
// any time, but the depth floor should only change while idle.
module depth_histogram_equalizer_unit #(
  parameter int DEPTH_BINS = dhe_pkg::DEPTH_BINS_DEF
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_we_i,
  input  logic [dhe_pkg::CFG_W-1:0] cfg_wdata_i,
  dhe_pix_if.sink                   pix_i,
  dhe_gray_if.source                gray_o
);
  import dhe_pkg::*;

  localparam int BIN_W = $clog2(DEPTH_BINS);
  localparam logic [DEPTH_W:0]  BINS_LIM = (DEPTH_W + 1)'(DEPTH_BINS);
  localparam logic [BIN_W-1:0]  LAST_BIN = BIN_W'(DEPTH_BINS - 1);

  // Sequencer states, one-hot.
  typedef enum logic [7:0] {
    ST_CLEAR  = 8'b0000_0001,
    ST_RUN    = 8'b0000_0010,
    ST_DRAIN  = 8'b0000_0100,
    ST_WRD    = 8'b0000_1000,
    ST_WACC   = 8'b0001_0000,
    ST_WSTART = 8'b0010_0000,
    ST_WDIV   = 8'b0100_0000,
    ST_WWR    = 8'b1000_0000
  } state_e;

  state_e             state_q, state_d;
  logic [CFG_W-1:0]   depth_floor_q;
  logic [BIN_W-1:0]   idx_q, idx_d;
  logic [COUNT_W-1:0] vp_q, vp_d;
  logic [COUNT_W-1:0] cum_q, cum_d;
  logic               gray_ok_q, gray_ok_d;

  // First pipeline stage: holds a pixel while its memory read is in flight.
  logic               s1_vld_q, s1_vld_d;
  logic               s1_mode_q;
  logic               s1_ok_q;
  logic [BIN_W-1:0]   s1_addr_q;

  // Record of the count written in the previous cycle, for forwarding.
  logic               fw_vld_q, fw_vld_d;
  logic [BIN_W-1:0]   fw_addr_q;
  logic [COUNT_W-1:0] fw_data_q;

  logic               out_vld_q, out_vld_d;
  logic [GRAY_W-1:0]  out_gray_q, out_gray_d;

  logic               pix_ok;
  logic [BIN_W-1:0]   pix_addr;
  logic               in_rdy;
  logic               pix_acc;
  logic               s1_free;
  logic               s1_cnt_wr;
  logic               out_move;
  logic [COUNT_W-1:0] cnt_cur;
  logic [COUNT_W-1:0] cnt_inc;
  logic [COUNT_W:0]   cum_sum;

  logic               cnt_re, cnt_we;
  logic [BIN_W-1:0]   cnt_raddr, cnt_waddr;
  logic [COUNT_W-1:0] cnt_wdata, cnt_rdata;

  logic               gray_re, gray_we;
  logic [GRAY_W-1:0]  gray_wdata, gray_rdata;

  div_req_t           div_req;
  div_rsp_t           div_rsp;

  // Depth zero is never valid, since the depth floor is at least zero.
  assign pix_ok   = ({1'b0, pix_i.depth} < BINS_LIM) &&
                    (pix_i.depth > DEPTH_W'(depth_floor_q));
  assign pix_addr = pix_i.depth[BIN_W-1:0];

  // A counting beat always leaves the first stage; a mapping beat leaves it
  // only when the output register is free or being emptied.
  assign s1_free  = !s1_vld_q || (s1_mode_q == MODE_COUNT) || !out_vld_q || gray_o.ready;
  assign in_rdy   = (state_q == ST_RUN) && s1_free;
  assign pix_acc  = pix_i.valid && in_rdy;
  assign out_move = s1_vld_q && (s1_mode_q == MODE_MAP) && (!out_vld_q || gray_o.ready);
  assign s1_cnt_wr = s1_vld_q && (s1_mode_q == MODE_COUNT) && s1_ok_q;

  // A count written in the previous cycle is not yet visible in the read data.
  assign cnt_cur = (fw_vld_q && (fw_addr_q == s1_addr_q)) ? fw_data_q : cnt_rdata;
  assign cnt_inc = (cnt_cur == COUNT_MAX) ? cnt_cur : cnt_cur + 1'b1;
  assign cum_sum = {1'b0, cum_q} + {1'b0, cnt_rdata};

  // Count memory port selection.
  always_comb begin
    cnt_re    = 1'b0;
    cnt_raddr = pix_addr;
    cnt_we    = 1'b0;
    cnt_waddr = s1_addr_q;
    cnt_wdata = cnt_inc;
    if (state_q == ST_WRD) begin
      cnt_re    = 1'b1;
      cnt_raddr = idx_q;
    end else if (pix_acc && (pix_i.mode == MODE_COUNT) && pix_ok) begin
      cnt_re = 1'b1;
    end
    if ((state_q == ST_CLEAR) || (state_q == ST_WACC)) begin
      cnt_we    = 1'b1;
      cnt_waddr = idx_q;
      cnt_wdata = '0;
    end else if (s1_cnt_wr) begin
      cnt_we = 1'b1;
    end
  end

  // Gray table ports: the walk writes, the mapping pass reads.
  assign gray_re    = pix_acc && (pix_i.mode == MODE_MAP);
  assign gray_we    = (state_q == ST_WWR);
  assign gray_wdata = (vp_q == '0) ? '0 : div_rsp.quot[GRAY_W-1:0];

  assign div_req.start = (state_q == ST_WSTART);
  assign div_req.num   = {vp_q - cum_q, {GRAY_W{1'b0}}};
  assign div_req.den   = vp_q;

  // Sequencer and walk bookkeeping.
  always_comb begin
    state_d   = state_q;
    idx_d     = idx_q;
    cum_d     = cum_q;
    gray_ok_d = gray_ok_q;
    vp_d      = vp_q;
    unique case (state_q)
      ST_CLEAR: begin
        if (idx_q == LAST_BIN) begin
          idx_d   = '0;
          state_d = ST_RUN;
        end else begin
          idx_d = idx_q + 1'b1;
        end
      end
      ST_RUN: begin
        if (pix_acc && (pix_i.mode == MODE_COUNT)) begin
          if (pix_ok && (vp_q != COUNT_MAX)) begin
            vp_d = vp_q + 1'b1;
          end
          if (pix_i.last) begin
            state_d = ST_DRAIN;
          end
        end
      end
      ST_DRAIN: begin
        state_d = ST_WRD;
      end
      ST_WRD: begin
        state_d = ST_WACC;
      end
      ST_WACC: begin
        // The running sum is clamped to N so the quotient stays in range.
        cum_d   = (cum_sum > {1'b0, vp_q}) ? vp_q : cum_sum[COUNT_W-1:0];
        state_d = ST_WSTART;
      end
      ST_WSTART: begin
        state_d = ST_WDIV;
      end
      ST_WDIV: begin
        if (div_rsp.done) begin
          state_d = ST_WWR;
        end
      end
      ST_WWR: begin
        if (idx_q == LAST_BIN) begin
          idx_d     = '0;
          cum_d     = '0;
          vp_d      = '0;
          gray_ok_d = 1'b1;
          state_d   = ST_RUN;
        end else begin
          idx_d   = idx_q + 1'b1;
          state_d = ST_WRD;
        end
      end
      default: begin
        state_d = ST_CLEAR;
      end
    endcase
  end

  always_comb begin
    s1_vld_d = pix_acc ? 1'b1 : (s1_free ? 1'b0 : s1_vld_q);
    fw_vld_d = s1_cnt_wr;
    out_vld_d = out_move ? 1'b1 : (gray_o.ready ? 1'b0 : out_vld_q);
    // Until the first walk the gray table still reads as all zero.
    out_gray_d = (s1_ok_q && gray_ok_q) ? gray_rdata : '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= ST_CLEAR;
      depth_floor_q <= '0;
      idx_q         <= '0;
      vp_q          <= '0;
      cum_q         <= '0;
      gray_ok_q     <= 1'b0;
      s1_vld_q      <= 1'b0;
      fw_vld_q      <= 1'b0;
      out_vld_q     <= 1'b0;
    end else begin
      state_q   <= state_d;
      if (cfg_we_i) begin
        depth_floor_q <= cfg_wdata_i;
      end
      idx_q     <= idx_d;
      vp_q      <= vp_d;
      cum_q     <= cum_d;
      gray_ok_q <= gray_ok_d;
      s1_vld_q  <= s1_vld_d;
      fw_vld_q  <= fw_vld_d;
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pix_acc) begin
      s1_mode_q <= pix_i.mode;
      s1_ok_q   <= pix_ok;
      s1_addr_q <= pix_addr;
    end
    if (s1_cnt_wr) begin
      fw_addr_q <= s1_addr_q;
      fw_data_q <= cnt_inc;
    end
    if (out_move) begin
      out_gray_q <= out_gray_d;
    end
  end

  assign pix_i.ready  = in_rdy;
  assign gray_o.valid = out_vld_q;
  assign gray_o.gray  = out_gray_q;

  dhe_ram #(
    .WIDTH (COUNT_W),
    .DEPTH (DEPTH_BINS)
  ) u_count_ram (
    .clk_i   (clk_i),
    .we_i    (cnt_we),
    .waddr_i (cnt_waddr),
    .wdata_i (cnt_wdata),
    .re_i    (cnt_re),
    .raddr_i (cnt_raddr),
    .rdata_o (cnt_rdata)
  );

  dhe_ram #(
    .WIDTH (GRAY_W),
    .DEPTH (DEPTH_BINS)
  ) u_gray_ram (
    .clk_i   (clk_i),
    .we_i    (gray_we),
    .waddr_i (idx_q),
    .wdata_i (gray_wdata),
    .re_i    (gray_re),
    .raddr_i (pix_addr),
    .rdata_o (gray_rdata)
  );

  dhe_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

endmodule

### sv/dhe_checker.sv
module dhe_checker (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        in_valid_i,
  input logic                        in_ready_i,
  input logic                        in_mode_i,
  input logic [dhe_pkg::DEPTH_W-1:0] in_depth_i,
  input logic                        in_last_i,
  input logic                        out_valid_i,
  input logic                        out_ready_i,
  input logic [dhe_pkg::GRAY_W-1:0]  out_gray_i
);
  import dhe_pkg::*;

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("result beat dropped while stalled");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> $stable(out_gray_i))
    else $error("result payload changed while stalled");

  // The final counting beat starts the bin walk, which holds off input.
  a_walk_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i && (in_mode_i == MODE_COUNT) && in_last_i |=> !in_ready_i)
    else $error("pixel taken right after the last counting beat");

  // With the output empty, a mapping beat reaches the output through the first stage and the output register.
  a_out_origin: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_i) |-> $past(in_valid_i && in_ready_i && (in_mode_i == MODE_MAP), 2))
    else $error("result beat without a mapping beat");

  a_zero_depth: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_i) && $past(in_valid_i && in_ready_i && (in_depth_i == '0), 2)
    |-> (out_gray_i == '0))
    else $error("depth zero mapped to nonzero gray");

endmodule

bind depth_histogram_equalizer_unit dhe_checker u_dhe_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (pix_i.valid),
  .in_ready_i  (pix_i.ready),
  .in_mode_i   (pix_i.mode),
  .in_depth_i  (pix_i.depth),
  .in_last_i   (pix_i.last),
  .out_valid_i (gray_o.valid),
  .out_ready_i (gray_o.ready),
  .out_gray_i  (gray_o.gray)
);

### verif/tb.sv
`timescale 1ns / 100ps

// Self-checking bench for the depth histogram equalizer.
//
// Every pixel beat that the block takes is fed to a scoreboard object that
// keeps its own copy of the bin counts, the valid-point total and the gray
// lookup table. A counting beat with last set runs the same cumulative walk
// the hardware does, so each mapping beat predicts its gray value the moment
// it is accepted. Gray beats are then matched in order against that queue.
module tb;
  import dhe_pkg::*;

  localparam int          BINS        = DEPTH_BINS_DEF;
  localparam int unsigned CYCLE_LIMIT = 3_000_000;
  localparam int          N_FRAMES    = 4;

  // Predicts the gray stream from the accepted pixel beats.
  class gray_tracker;
    bit [COUNT_W-1:0] bin_cnt [BINS];
    bit [GRAY_W-1:0]  gray_lut [BINS];
    bit [COUNT_W-1:0] n_valid;
    bit [CFG_W-1:0]   depth_floor;
    bit [GRAY_W-1:0]  gray_due [$];
    int unsigned      n_pix, n_gray, n_walks, n_cfg, n_bad;

    function void set_depth_floor(bit [CFG_W-1:0] v);
      depth_floor = v;
      n_cfg++;
    endfunction

    function bit depth_ok(bit [DEPTH_W-1:0] d);
      return d != 0 && d > depth_floor && d < BINS;
    endfunction

    // Cumulative walk: gray = floor(256*(N-cum)/N), kept to eight bits, so a
    // bin with nothing at or below it wraps 256 down to zero.
    function void equalize_bins();
      longint unsigned n, cum, q;
      n   = n_valid;
      cum = 0;
      gray_lut[0] = '0;
      for (int i = 1; i < BINS; i++) begin
        cum += bin_cnt[i];
        if (cum > n) cum = n;
        q = (n == 0) ? 0 : (256 * (n - cum)) / n;
        gray_lut[i] = q[GRAY_W-1:0];
      end
      foreach (bin_cnt[j]) bin_cnt[j] = '0;
      n_valid = '0;
      n_walks++;
    endfunction

    function void note_pixel(bit mode, bit [DEPTH_W-1:0] d, bit last);
      n_pix++;
      if (mode == MODE_COUNT) begin
        if (depth_ok(d)) begin
          if (bin_cnt[d] != COUNT_MAX) bin_cnt[d]++;
          if (n_valid != COUNT_MAX) n_valid++;
        end
        if (last) equalize_bins();
      end else begin
        gray_due.push_back(depth_ok(d) ? gray_lut[d] : '0);
      end
    endfunction

    function void check_gray(logic [GRAY_W-1:0] got);
      bit [GRAY_W-1:0] want;
      n_gray++;
      if (gray_due.size() == 0) begin
        n_bad++;
        if (n_bad <= 10) $display("gray beat %0d: got %0d, none expected", n_gray, got);
        return;
      end
      want = gray_due.pop_front();
      if (got !== want) begin
        n_bad++;
        if (n_bad <= 10)
          $display("gray beat %0d: expected %0d, got %0d", n_gray, want, got);
      end
    endfunction

    function int pending();
      return gray_due.size();
    endfunction
  endclass

  logic clk_i;
  logic rst_ni;
  logic cfg_we_i;
  logic [CFG_W-1:0] cfg_wdata_i;

  dhe_pix_if  pix_bus ();
  dhe_gray_if gray_bus ();

  depth_histogram_equalizer_unit #(
    .DEPTH_BINS(BINS)
  ) u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i),
    .pix_i      (pix_bus),
    .gray_o     (gray_bus)
  );

  gray_tracker sb = new();

  int unsigned cycles = 0;
  int unsigned burst_left = 1;
  bit          pix_up = 1'b0;
  int unsigned rx_left = 0;
  int unsigned rx_mode = 0;

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // Every input starts at a known value before the first edge.
  initial begin
    rst_ni         = 1'b0;
    cfg_we_i       = 1'b0;
    cfg_wdata_i    = '0;
    pix_bus.valid  = 1'b0;
    pix_bus.mode   = MODE_COUNT;
    pix_bus.depth  = '0;
    pix_bus.last   = 1'b0;
    gray_bus.ready = 1'b0;
  end

  // Result side: every so often pick a new stall style and keep it for a
  // stretch. Style zero never stalls, the others stall randomly, on a fixed
  // period, or for long runs.
  always @(posedge clk_i) begin
    if (rx_left == 0) begin
      rx_mode <= $urandom_range(0, 3);
      rx_left <= $urandom_range(20, 300);
    end else begin
      rx_left <= rx_left - 1;
    end
    case (rx_mode)
      0:       gray_bus.ready <= 1'b1;
      1:       gray_bus.ready <= ($urandom_range(0, 3) != 0);
      2:       gray_bus.ready <= (cycles % 7) < 3;
      default: gray_bus.ready <= ($urandom_range(0, 9) == 0);
    endcase
  end

  // Both channels are sampled at the edge, before any driver update lands.
  // The result is checked first so a beat never sees its own expectation.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (gray_bus.valid && gray_bus.ready) sb.check_gray(gray_bus.gray);
      if (pix_bus.valid && pix_bus.ready)
        sb.note_pixel(pix_bus.mode, pix_bus.depth, pix_bus.last);
    end
  end

  // Watchdog. A correct run with six bin walks stays far below the limit.
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles, %0d gray beats still due", cycles, sb.pending());
      $display("Mismatches found");
      $finish;
    end
  end

  // Drives one pixel beat and returns at the edge that accepts it. The sender
  // works in bursts; when one ends it may drop valid for a random gap.
  task automatic send_pixel(input logic m, input logic [DEPTH_W-1:0] d, input logic l);
    int unsigned gap;
    pix_bus.valid <= 1'b1;
    pix_bus.mode  <= m;
    pix_bus.depth <= d;
    pix_bus.last  <= l;
    pix_up = 1'b1;
    @(posedge clk_i);
    while (!pix_bus.ready) @(posedge clk_i);
    burst_left--;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap != 0) begin
        pix_bus.valid <= 1'b0;
        pix_up = 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
  endtask

  task automatic pix_idle();
    if (pix_up) begin
      pix_bus.valid <= 1'b0;
      pix_up = 1'b0;
      @(posedge clk_i);
    end
  endtask

  // Waits until every predicted gray beat has come back, then lets the
  // mapping pipe settle with some margin.
  task automatic wait_drained();
    pix_idle();
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic write_depth_floor(input logic [CFG_W-1:0] v);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    sb.set_depth_floor(v);
  endtask

  // Mostly clustered depths so the histogram has shape, with a share of full
  // range samples, zeros, threshold hits and depths at or just past the last bin.
  function automatic logic [DEPTH_W-1:0] make_depth(input int unsigned center,
                                                    input int unsigned spread,
                                                    input int unsigned md);
    int unsigned r;
    r = $urandom_range(0, 19);
    if (r < 15) return DEPTH_W'(center + $urandom_range(0, spread));
    if (r < 17) return DEPTH_W'($urandom);
    if (r == 17) return '0;
    if (r == 18) return DEPTH_W'(md + $urandom_range(0, 1));
    return DEPTH_W'(BINS - 1 + $urandom_range(0, 3));
  endfunction

  // One well-formed frame: a counting pass closed by last, with a few stray
  // mapping beats mixed in, then a mapping pass that mostly revisits the
  // depths just counted.
  task automatic random_frame(input logic [CFG_W-1:0] md);
    logic [DEPTH_W-1:0] seen [$];
    logic [DEPTH_W-1:0] d;
    int unsigned n_count, n_map, center, spread;
    write_depth_floor(md);
    center  = $urandom_range(md + 1, BINS - 1);
    spread  = $urandom_range(0, 200);
    n_count = $urandom_range(90, 150);
    n_map   = $urandom_range(90, 130);
    for (int k = 0; k < n_count; k++) begin
      d = make_depth(center, spread, md);
      if ($urandom_range(0, 19) == 0) begin
        send_pixel(MODE_MAP, d, 1'($urandom_range(0, 1)));
      end else begin
        seen.push_back(d);
        send_pixel(MODE_COUNT, d, 1'b0);
      end
    end
    d = make_depth(center, spread, md);
    seen.push_back(d);
    send_pixel(MODE_COUNT, d, 1'b1);
    for (int k = 0; k < n_map; k++) begin
      if ($urandom_range(0, 9) < 7) d = seen[$urandom_range(0, seen.size() - 1)];
      else d = make_depth(center, spread, md);
      send_pixel(MODE_MAP, d, (k == n_map - 1) || ($urandom_range(0, 19) == 0));
    end
    wait_drained();
  endtask

  initial begin
    logic [CFG_W-1:0] md_set [N_FRAMES];
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    write_depth_floor('0);

    // Mapping before any walk reads the reset table, so all of these are zero,
    // including one with last set in map mode.
    send_pixel(MODE_MAP, 16'd5, 1'b0);
    send_pixel(MODE_MAP, 16'd8191, 1'b0);
    send_pixel(MODE_MAP, 16'hFFFF, 1'b1);

    // Back-to-back repeats of one depth exercise the count forwarding path.
    // Depth zero and the first depth past the bins are not counted.
    send_pixel(MODE_COUNT, 16'd5, 1'b0);
    send_pixel(MODE_COUNT, 16'd5, 1'b0);
    send_pixel(MODE_COUNT, 16'd5, 1'b0);
    send_pixel(MODE_COUNT, 16'd1, 1'b0);
    send_pixel(MODE_COUNT, 16'd8191, 1'b0);
    send_pixel(MODE_COUNT, 16'd0, 1'b0);
    send_pixel(MODE_COUNT, 16'd8192, 1'b0);
    send_pixel(MODE_COUNT, 16'd4096, 1'b1);
    send_pixel(MODE_MAP, 16'd0, 1'b0);
    send_pixel(MODE_MAP, 16'd1, 1'b0);
    send_pixel(MODE_MAP, 16'd5, 1'b0);
    send_pixel(MODE_MAP, 16'd4096, 1'b0);
    send_pixel(MODE_MAP, 16'd8191, 1'b0);
    send_pixel(MODE_MAP, 16'd8192, 1'b1);
    wait_drained();

    // With the threshold at its top nothing is valid, so the walk sees no
    // points at all and the whole table goes to zero. The mapping beat also
    // holds the sender off until that walk has finished.
    write_depth_floor('1);
    send_pixel(MODE_COUNT, 16'd8191, 1'b0);
    send_pixel(MODE_COUNT, 16'd100, 1'b0);
    send_pixel(MODE_COUNT, 16'd9000, 1'b1);
    send_pixel(MODE_MAP, 16'd100, 1'b0);
    wait_drained();

    // Lower the threshold again to read the all-zero table at valid depths.
    write_depth_floor('0);
    send_pixel(MODE_MAP, 16'd5, 1'b0);
    send_pixel(MODE_MAP, 16'd4096, 1'b1);
    wait_drained();

    // Random frames, each under its own threshold, one of them zero.
    md_set[0] = '0;
    md_set[1] = CFG_W'($urandom_range(1, 500));
    md_set[2] = CFG_W'($urandom_range(500, 2000));
    md_set[3] = CFG_W'($urandom_range(2000, 7000));
    md_set.shuffle();
    foreach (md_set[f]) random_frame(md_set[f]);

    if (sb.pending() != 0) sb.n_bad++;
    $display("Covered %0d pixel beats and %0d gray beats over %0d bin walks,",
             sb.n_pix, sb.n_gray, sb.n_walks);
    $display("with %0d threshold writes; %0d mismatches.", sb.n_cfg, sb.n_bad);
    if (sb.n_bad == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
